// File: sv/clt_pkg.sv
package clt_pkg;

	localparam int MAX_RES = 3;
	localparam int CNT_W   = 2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef enum logic [3:0] {
		PH_SKIP     = 4'd0,
		PH_SLASH    = 4'd1,
		PH_COMMENT  = 4'd2,
		PH_CSTAR    = 4'd3,
		PH_IGNORE   = 4'd4,
		PH_UNQUOTED = 4'd5,
		PH_UNQ_ESC  = 4'd6,
		PH_QUOTED   = 4'd7,
		PH_Q_ESC    = 4'd8
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		logic [MAX_RES-1:0][7:0]  ch;
		logic [MAX_RES-1:0]       eos;
	} res_t;

endpackage

// File: sv/command_line_tokenizer_top.sv
// Command-line tokenizer.
// Input channel (in_valid, in_stall, ch): one byte of a command string per
// item; byte 0 ends the string.
// Output channel (out_valid, out_stall, out_ch, end_of_string): token bytes
// and single separator spaces, then one end marker (end_of_string = 1,
// out_ch = 0) for every string.
// An input byte yields zero to three result items. It enters a two-entry
// input queue, is decoded by the tokenizer state machine and lands in a
// result register, from which its results are offered. Bytes are accepted
// at one per cycle while in_stall is low; a byte with several results holds
// the output port until all are taken, so the output port sets the rate.
// in_stall comes from the input queue fill alone.
// When out_stall is high the current result holds, the result register and
// then the input queue fill, and in_stall rises once the queue holds two bytes.
// Reset empties the queue and result register and returns the tokenizer to
// skipping whitespace with no separator owed.
module command_line_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_ch,
	output logic       end_of_string
);
	import clt_pkg::*;

	logic       fifo_valid;
	logic [7:0] fifo_ch;
	logic       pop;
	logic       load_ok;
	res_t       res;

	clt_in_fifo u_in_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ch         (ch),
		.fifo_valid (fifo_valid),
		.fifo_ch    (fifo_ch),
		.pop        (pop)
	);

	clt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_ch    (fifo_ch),
		.load_ok    (load_ok),
		.pop        (pop),
		.res        (res)
	);

	clt_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.load          (pop),
		.load_ok       (load_ok),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_ch        (out_ch),
		.end_of_string (end_of_string)
	);

endmodule

// File: sv/clt_in_fifo.sv
module clt_in_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	output logic       fifo_valid,
	output logic [7:0] fifo_ch,
	input  logic       pop
);
	import clt_pkg::*;

	logic [1:0][7:0] mem_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign fifo_valid = (count_q != 2'd0);
	assign fifo_ch    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != 2'd0))
		else $error("pop from empty input queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("input queue count overflow");
	a_ptr_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("input queue pointers out of step");
`endif

endmodule

// File: sv/clt_core.sv
module clt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fifo_valid,
	input  logic [7:0]    fifo_ch,
	input  logic          load_ok,
	output logic          pop,
	output clt_pkg::res_t res
);
	import clt_pkg::*;

	typedef struct packed {
		phase_t                  phase;
		logic                    sep;
		logic [CNT_W-1:0]        n;
		logic [MAX_RES-1:0][7:0] ch;
		logic [MAX_RES-1:0]      eos;
	} step_t;

	phase_t phase_q;
	logic   sep_q;
	step_t  nxt;

	function automatic step_t put(step_t s, logic [7:0] c, logic e);
		step_t r;
		r        = s;
		r.ch[r.n]  = c;
		r.eos[r.n] = e;
		r.n      = r.n + 2'd1;
		return r;
	endfunction

	function automatic step_t put_tok(step_t s, logic [7:0] c);
		step_t r;
		r = s;
		if (r.sep) begin
			r     = put(r, CH_SPACE, 1'b0);
			r.sep = 1'b0;
		end
		return put(r, c, 1'b0);
	endfunction

	function automatic step_t finish(step_t s);
		step_t r;
		r       = s;
		r.sep   = 1'b0;
		r.phase = PH_SKIP;
		return put(r, CH_NUL, 1'b1);
	endfunction

	function automatic step_t end_token(step_t s, logic [7:0] b);
		step_t r;
		r = s;
		if (r.sep) begin
			r = put(r, CH_SPACE, 1'b0);
		end
		r.sep = 1'b1;
		if (b == CH_NUL) begin
			r = finish(r);
		end else begin
			r.phase = PH_SKIP;
		end
		return r;
	endfunction

	function automatic step_t unquoted(step_t s, logic [7:0] b);
		step_t r;
		r = s;
		if (b == CH_QUOTE) begin
			r.phase = PH_QUOTED;
		end else if (b > CH_SPACE) begin
			if (b == CH_BSLASH) begin
				r.phase = PH_UNQ_ESC;
			end else begin
				r.phase = PH_UNQUOTED;
				r       = put_tok(r, b);
			end
		end else begin
			r = end_token(r, b);
		end
		return r;
	endfunction

	always_comb begin
		nxt       = '0;
		nxt.phase = phase_q;
		nxt.sep   = sep_q;
		unique case (phase_q)
			PH_SLASH: begin
				if (fifo_ch == CH_SLASH) begin
					nxt.phase = PH_IGNORE;
				end else if (fifo_ch == CH_STAR) begin
					nxt.phase = PH_COMMENT;
				end else begin
					nxt = put_tok(nxt, CH_SLASH);
					nxt = unquoted(nxt, fifo_ch);
				end
			end
			PH_COMMENT: begin
				if (fifo_ch == CH_NUL) begin
					nxt = finish(nxt);
				end else if (fifo_ch == CH_STAR) begin
					nxt.phase = PH_CSTAR;
				end
			end
			PH_CSTAR: begin
				if (fifo_ch == CH_NUL) begin
					nxt = finish(nxt);
				end else if (fifo_ch == CH_SLASH) begin
					nxt.phase = PH_SKIP;
				end else if (fifo_ch != CH_STAR) begin
					nxt.phase = PH_COMMENT;
				end
			end
			PH_IGNORE: begin
				if (fifo_ch == CH_NUL) begin
					nxt = finish(nxt);
				end
			end
			PH_UNQUOTED: begin
				nxt = unquoted(nxt, fifo_ch);
			end
			PH_UNQ_ESC: begin
				if (fifo_ch < CH_SPACE) begin
					nxt = end_token(nxt, fifo_ch);
				end else begin
					nxt       = put_tok(nxt, fifo_ch);
					nxt.phase = PH_UNQUOTED;
				end
			end
			PH_QUOTED: begin
				if (fifo_ch == CH_NUL) begin
					nxt = end_token(nxt, fifo_ch);
				end else if (fifo_ch == CH_QUOTE) begin
					nxt.phase = PH_UNQUOTED;
				end else if (fifo_ch == CH_BSLASH) begin
					nxt.phase = PH_Q_ESC;
				end else begin
					nxt = put_tok(nxt, fifo_ch);
				end
			end
			PH_Q_ESC: begin
				if (fifo_ch == CH_NUL) begin
					nxt = end_token(nxt, fifo_ch);
				end else if (fifo_ch < CH_SPACE) begin
					nxt.phase = PH_UNQUOTED;
				end else begin
					nxt       = put_tok(nxt, fifo_ch);
					nxt.phase = PH_QUOTED;
				end
			end
			default: begin
				if (fifo_ch == CH_NUL) begin
					nxt = finish(nxt);
				end else if (fifo_ch <= CH_SPACE) begin
					nxt.phase = PH_SKIP;
				end else if (fifo_ch == CH_SLASH) begin
					nxt.phase = PH_SLASH;
				end else begin
					nxt = unquoted(nxt, fifo_ch);
				end
			end
		endcase
	end

	assign pop     = fifo_valid && load_ok;
	assign res.cnt = nxt.n;
	assign res.ch  = nxt.ch;
	assign res.eos = nxt.eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			sep_q   <= 1'b0;
		end else if (pop) begin
			phase_q <= nxt.phase;
			sep_q   <= nxt.sep;
		end
	end

`ifndef SYNTHESIS
	a_nul_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (fifo_ch == CH_NUL)) |=> ((phase_q == PH_SKIP) && !sep_q))
		else $error("terminator did not return to start phase");
	a_nul_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (fifo_ch == CH_NUL)) |-> (res.eos[res.cnt - 2'd1] && (res.cnt != 2'd0)))
		else $error("terminator without end marker");
	a_comment_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && ((phase_q == PH_COMMENT) || (phase_q == PH_CSTAR)
			|| (phase_q == PH_IGNORE)) && (fifo_ch != CH_NUL)) |-> (res.cnt == 2'd0))
		else $error("comment byte produced output");
`endif

endmodule

// File: sv/clt_out_buf.sv
module clt_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  clt_pkg::res_t res,
	input  logic          load,
	output logic          load_ok,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_ch,
	output logic          end_of_string
);
	import clt_pkg::*;

	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic [MAX_RES-1:0][7:0] ch_q;
	logic [MAX_RES-1:0]      eos_q;
	logic                    take;
	logic                    last;

	assign out_valid     = (cnt_q != '0);
	assign take          = out_valid && !out_stall;
	assign last          = (idx_q == (cnt_q - 2'd1));
	assign load_ok       = !out_valid || (take && last);
	assign out_ch        = ch_q[idx_q];
	assign end_of_string = eos_q[idx_q];

	always_ff @(posedge clk) begin
		if (load) begin
			ch_q  <= res.ch;
			eos_q <= res.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < cnt_q))
		else $error("result index beyond count");
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_string) |-> last)
		else $error("end marker not the final result");
	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> load_ok)
		else $error("result set overwritten before delivery");
`endif

endmodule
